[sv/sbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants of the bond extractor: request and result
// payloads, character classes, queue entry and sizing constants.
// ----------------------------------------------------------------------------
package sbe_pkg;

	// Sizing
	localparam int MAX_ATOMS   = 256;
	localparam int STACK_DEPTH = 16;
	localparam int RING_LABELS = 10;
	localparam int QUEUE_DEPTH = 4;

	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 8;   // emitted atom index width
	localparam int ORDER_W = 2;
	localparam int ATOM_W  = (MAX_ATOMS > 2) ? $clog2(MAX_ATOMS) : 1;
	localparam int CNT_W   = $clog2(MAX_ATOMS + 1);
	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W  = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam int RING_W  = $clog2(RING_LABELS);
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	// Characters
	localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;  // '-'
	localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;  // '='
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;  // '#'
	localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;  // '('
	localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;  // ')'
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;  // '0'
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;  // '9'
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

	// Bond orders
	localparam logic [ORDER_W-1:0] ORDER_SINGLE = 2'd1;
	localparam logic [ORDER_W-1:0] ORDER_DOUBLE = 2'd2;
	localparam logic [ORDER_W-1:0] ORDER_TRIPLE = 2'd3;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_ATOM,
		CLS_ORDER,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_RING
	} sbe_cls_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              first;
	} sbe_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]   atom_from;
		logic [IDX_W-1:0]   atom_to;
		logic [ORDER_W-1:0] multiplicity;
		logic               overflow;
	} sbe_bond_t;

	// Classified character as it travels from front to back
	typedef struct packed {
		sbe_cls_t           cls;
		logic [ORDER_W-1:0] order;
		logic [RING_W-1:0]  ring;
		logic               first;
	} sbe_entry_t;

endpackage

[sv/sbe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_front
// Accepts characters and classifies them into atom, bond order, branch open,
// branch close, ring digit or ignored, ready for the queue.
// ----------------------------------------------------------------------------
module sbe_front (
	input  logic              char_valid,
	output logic              char_stall,
	input  sbe_pkg::sbe_req_t char_data,
	output logic              push,
	output sbe_pkg::sbe_entry_t entry,
	input  logic              full
);
	import sbe_pkg::*;

	logic [CHAR_W-1:0] c;
	logic [CHAR_W-1:0] digit;

	assign c     = char_data.char_code;
	assign digit = c - CH_ZERO;

	assign char_stall = full;
	assign push       = char_valid && !full;

	always_comb begin
		entry.cls   = CLS_NONE;
		entry.order = ORDER_SINGLE;
		entry.ring  = digit[RING_W-1:0];
		entry.first = char_data.first;
		if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
			entry.cls = CLS_ATOM;
		end else if (c == CH_DASH) begin
			entry.cls   = CLS_ORDER;
			entry.order = ORDER_SINGLE;
		end else if (c == CH_EQUAL) begin
			entry.cls   = CLS_ORDER;
			entry.order = ORDER_DOUBLE;
		end else if (c == CH_HASH) begin
			entry.cls   = CLS_ORDER;
			entry.order = ORDER_TRIPLE;
		end else if (c == CH_OPEN) begin
			entry.cls = CLS_OPEN;
		end else if (c == CH_CLOSE) begin
			entry.cls = CLS_CLOSE;
		end else if (c >= CH_ZERO && c <= CH_NINE && digit < CHAR_W'(RING_LABELS)) begin
			entry.cls = CLS_RING;
		end
	end

endmodule

[sv/sbe_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_queue
// Short FIFO of classified characters between the front and back parts.
// ----------------------------------------------------------------------------
module sbe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sbe_pkg::sbe_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output sbe_pkg::sbe_entry_t pop_entry,
	output logic                empty
);
	import sbe_pkg::*;

	sbe_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/sbe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_back
// Parser state: atom counter, pending order, branch stack and ring table.
// Executes one classified character per cycle while the bond output is not stalled, and registers the bond.
// ----------------------------------------------------------------------------
module sbe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  sbe_pkg::sbe_entry_t entry,
	output logic                pop,
	output logic                bond_valid,
	input  logic                bond_stall,
	output sbe_pkg::sbe_bond_t  bond_data
);
	import sbe_pkg::*;

	// Architectural state
	logic [ATOM_W-1:0]  last_atom_q;
	logic               have_atom_q;
	logic [CNT_W-1:0]   atom_cnt_q;
	logic [ORDER_W-1:0] pend_order_q;
	logic [SP_W-1:0]    sp_q;
	logic [RING_LABELS-1:0] ring_seen_q;
	logic               err_q;
	logic [ATOM_W-1:0]  stack_q [STACK_DEPTH];
	logic [ATOM_W-1:0]  ring_atom_q [RING_LABELS];

	// View after an optional clear by the first flag
	logic [ATOM_W-1:0]  last_eff;
	logic               have_eff;
	logic [CNT_W-1:0]   cnt_eff;
	logic [ORDER_W-1:0] order_eff;
	logic [SP_W-1:0]    sp_eff;
	logic [RING_LABELS-1:0] seen_eff;
	logic               err_eff;

	// Next state
	logic [ATOM_W-1:0]  last_nxt;
	logic               have_nxt;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [ORDER_W-1:0] order_nxt;
	logic [SP_W-1:0]    sp_nxt;
	logic [RING_LABELS-1:0] seen_nxt;
	logic               err_nxt;

	logic               stk_we;
	logic               ring_we;
	logic [SP_W-1:0]    sp_dec;
	logic               emit;
	sbe_bond_t          bond_nxt;
	logic               out_free;
	sbe_bond_t          bond_q;
	logic               bond_valid_q;

	assign out_free = !bond_valid_q || !bond_stall;
	assign pop      = out_free && !empty;
	assign sp_dec   = sp_eff - 1'b1;

	always_comb begin
		last_eff  = entry.first ? '0 : last_atom_q;
		have_eff  = entry.first ? 1'b0 : have_atom_q;
		cnt_eff   = entry.first ? '0 : atom_cnt_q;
		order_eff = entry.first ? ORDER_SINGLE : pend_order_q;
		sp_eff    = entry.first ? '0 : sp_q;
		seen_eff  = entry.first ? '0 : ring_seen_q;
		err_eff   = entry.first ? 1'b0 : err_q;
	end

	always_comb begin
		last_nxt  = last_eff;
		have_nxt  = have_eff;
		cnt_nxt   = cnt_eff;
		order_nxt = order_eff;
		sp_nxt    = sp_eff;
		seen_nxt  = seen_eff;
		err_nxt   = err_eff;
		stk_we    = 1'b0;
		ring_we   = 1'b0;
		emit      = 1'b0;
		bond_nxt.atom_from    = IDX_W'(last_eff);
		bond_nxt.atom_to      = IDX_W'(cnt_eff);
		bond_nxt.multiplicity = order_eff;
		unique case (entry.cls)
			CLS_ATOM: begin
				if (cnt_eff >= CNT_W'(MAX_ATOMS)) begin
					err_nxt = 1'b1;
				end else begin
					emit      = have_eff;
					last_nxt  = cnt_eff[ATOM_W-1:0];
					have_nxt  = 1'b1;
					order_nxt = ORDER_SINGLE;
					cnt_nxt   = cnt_eff + 1'b1;
				end
			end
			CLS_ORDER: begin
				order_nxt = entry.order;
			end
			CLS_OPEN: begin
				if (sp_eff >= SP_W'(STACK_DEPTH)) begin
					err_nxt = 1'b1;
				end else begin
					stk_we = 1'b1;
					sp_nxt = sp_eff + 1'b1;
				end
			end
			CLS_CLOSE: begin
				if (sp_eff == '0) begin
					err_nxt = 1'b1;
				end else begin
					sp_nxt   = sp_dec;
					last_nxt = stack_q[sp_dec[SIDX_W-1:0]];
				end
			end
			CLS_RING: begin
				if (have_eff) begin
					if (!seen_eff[entry.ring]) begin
						ring_we = 1'b1;
						seen_nxt[entry.ring] = 1'b1;
					end else begin
						emit = 1'b1;
						bond_nxt.atom_from    = IDX_W'(ring_atom_q[entry.ring]);
						bond_nxt.atom_to      = IDX_W'(last_eff);
						bond_nxt.multiplicity = ORDER_SINGLE;
					end
				end
			end
			default: begin
			end
		endcase
		bond_nxt.overflow = err_nxt;
	end

	always_ff @(posedge clk) begin
		if (pop && stk_we) begin
			stack_q[sp_eff[SIDX_W-1:0]] <= last_eff;
		end
		if (pop && ring_we) begin
			ring_atom_q[entry.ring] <= last_eff;
		end
		if (pop && emit) begin
			bond_q <= bond_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_atom_q  <= '0;
			have_atom_q  <= 1'b0;
			atom_cnt_q   <= '0;
			pend_order_q <= ORDER_SINGLE;
			sp_q         <= '0;
			ring_seen_q  <= '0;
			err_q        <= 1'b0;
			bond_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				last_atom_q  <= last_nxt;
				have_atom_q  <= have_nxt;
				atom_cnt_q   <= cnt_nxt;
				pend_order_q <= order_nxt;
				sp_q         <= sp_nxt;
				ring_seen_q  <= seen_nxt;
				err_q        <= err_nxt;
			end
			// hold the bond while stalled, else load or drop
			if (out_free) begin
				bond_valid_q <= pop && emit;
			end
		end
	end

	assign bond_valid = bond_valid_q;
	assign bond_data  = bond_q;

endmodule

[sv/smiles_bond_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smiles_bond_extractor
// Streams a SMILES-like string one character per request and emits bond
// edges: atoms, branches, bond orders and ring closures.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  char    | char_valid, char_stall | char_code, first
//  bond    | bond_valid, bond_stall | atom_from, atom_to, multiplicity, overflow
//
// One character per cycle while bond is not stalled; the back end updates parser
// state once per request and registers the bond, so a character is held in the
// queue and its bond, if any, in the output register.
// A four-entry queue decouples the classifier from the state update.
// Reset clears the queue, the parser state and the output register.
// A stall on bond stops the back end; the queue then fills and char_stall rises.
// ----------------------------------------------------------------------------
module smiles_bond_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  sbe_pkg::sbe_req_t  char_data,
	output logic               bond_valid,
	input  logic               bond_stall,
	output sbe_pkg::sbe_bond_t bond_data
);
	import sbe_pkg::*;

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	sbe_entry_t q_in;
	sbe_entry_t q_out;

	sbe_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.push       (q_push),
		.entry      (q_in),
		.full       (q_full)
	);

	sbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_out),
		.empty      (q_empty)
	);

	sbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.entry      (q_out),
		.pop        (q_pop),
		.bond_valid (bond_valid),
		.bond_stall (bond_stall),
		.bond_data  (bond_data)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue reports full and empty together");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");

	a_bond_order: assert property (@(posedge clk) disable iff (!arst_n)
		bond_valid |-> (bond_data.multiplicity != '0))
		else $error("bond with order zero");

	a_stall_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(bond_valid && bond_stall) |-> !q_pop)
		else $error("back end advanced while result was stalled");

endmodule
